@@ rtl/assert_macros.svh @@
// assertion macros for the rtl file that checks itself (ppm_stream_parser_core)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/pps_pkg.sv @@
// types and constants for the ppm stream parser
`default_nettype none

package pps_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_MAXCOLOR = 3'd2;
    localparam logic [2:0] ERR_CHAR     = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    // characters of interest
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // only legal maxcolor, also the largest ascii component
    localparam logic [7:0] COLOUR_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } pps_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        binary_format;
        logic        last;
        logic [2:0]  error_code;
    } pps_out_t;

    // byte classification handed to the parser
    typedef struct packed {
        logic       is_digit;
        logic       is_space;
        logic       is_hash;
        logic       is_lf;
        logic       is_p;
        logic       is_three;
        logic       is_six;
        logic [3:0] digit;
    } pps_class_t;

endpackage

`default_nettype wire

@@ rtl/pps_byte_class.sv @@
// character classifier for the ppm stream parser
`default_nettype none

module pps_byte_class (
    input  logic [7:0]         data_byte,
    output pps_pkg::pps_class_t cls
);
    import pps_pkg::*;

    logic [7:0] offset;

    assign offset = data_byte - CH_0;

    always_comb
    begin
        cls.is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
        cls.is_space = (data_byte == CH_SPACE) || (data_byte == CH_TAB)
                    || (data_byte == CH_CR) || (data_byte == CH_LF);
        cls.is_hash  = (data_byte == CH_HASH);
        cls.is_lf    = (data_byte == CH_LF);
        cls.is_p     = (data_byte == CH_P);
        cls.is_three = (data_byte == CH_3);
        cls.is_six   = (data_byte == CH_6);
        cls.digit    = offset[3:0];
    end

endmodule

`default_nettype wire

@@ rtl/pps_parser.sv @@
// header and pixel parsing state with its per-byte update
`default_nettype none

module pps_parser #(
    parameter int DIM_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  pps_pkg::pps_in_t    item,
    input  pps_pkg::pps_class_t cls,
    output logic                emit,
    output pps_pkg::pps_out_t   result
);
    import pps_pkg::*;

    localparam int ACC_W = DIM_BITS + 1;
    localparam int NV_W  = ACC_W + 4;
    localparam int PC_W  = 2 * DIM_BITS;
    localparam logic [NV_W-1:0] DIM_MAX =
        {{(NV_W - DIM_BITS){1'b0}}, {DIM_BITS{1'b1}}};
    localparam logic [NV_W-1:0] MAXC_SAT = NV_W'(9'd256);

    typedef enum logic [5:0] {
        PH_MAGIC  = 6'b000001,
        PH_WIDTH  = 6'b000010,
        PH_HEIGHT = 6'b000100,
        PH_MAXC   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_HALT   = 6'b100000
    } phase_t;

    phase_t              phase_reg,   phase_next;
    logic                comment_reg, comment_next;
    logic                tok_reg,     tok_next;
    logic [1:0]          magic_reg,   magic_next;
    logic [ACC_W-1:0]    acc_reg,     acc_next;
    logic [DIM_BITS-1:0] width_reg,   width_next;
    logic [DIM_BITS-1:0] height_reg,  height_next;
    logic                fmt_reg,     fmt_next;
    logic [1:0]          comp_reg,    comp_next;
    logic [7:0]          red_reg,     red_next;
    logic [7:0]          green_reg,   green_next;
    logic [PC_W-1:0]     count_reg,   count_next;
    logic [PC_W-1:0]     total_reg;

    logic [NV_W-1:0]      nv;
    logic [ACC_W-1:0]     acc_val;
    logic [PC_W-1:0]      count_inc;
    logic [DIM_BITS+15:0] width_ext;
    logic [DIM_BITS+15:0] height_ext;

    logic             do_fail;
    logic [2:0]       fail_code;
    logic             do_fin;
    logic [ACC_W-1:0] fin_val;
    logic             do_take;
    logic [7:0]       take_val;

    // acc * 10 + digit
    assign nv = {1'b0, acc_reg, 3'b000} + {{3{1'b0}}, acc_reg, 1'b0}
              + {{(NV_W - 4){1'b0}}, cls.digit};
    assign count_inc  = count_reg + PC_W'(1);
    assign width_ext  = {16'h0000, width_reg};
    assign height_ext = {16'h0000, height_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        comment_next = comment_reg;
        tok_next     = tok_reg;
        magic_next   = magic_reg;
        acc_next     = acc_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        fmt_next     = fmt_reg;
        comp_next    = comp_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        result       = '0;
        do_fail      = 1'b0;
        fail_code    = ERR_NONE;
        do_fin       = 1'b0;
        fin_val      = acc_reg;
        do_take      = 1'b0;
        take_val     = item.data_byte;
        acc_val      = acc_reg;

        // byte path
        unique case (phase_reg)
            PH_HALT:
            begin
            end
            PH_MAGIC:
            begin
                if (magic_reg == 2'd0)
                begin
                    if (!cls.is_p)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_MAGIC;
                    end
                    magic_next = 2'd1;
                end
                else if (magic_reg == 2'd1)
                begin
                    if (!cls.is_three && !cls.is_six)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_MAGIC;
                    end
                    fmt_next   = cls.is_six;
                    magic_next = 2'd2;
                end
                else
                begin
                    if (cls.is_hash)
                        comment_next = 1'b1;
                    else if (!cls.is_space)
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_MAGIC;
                    end
                    phase_next = PH_WIDTH;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXC, PH_DATA:
            begin
                if (comment_reg)
                begin
                    if (cls.is_lf)
                        comment_next = 1'b0;
                end
                else if ((phase_reg == PH_DATA) && fmt_reg)
                begin
                    do_take  = 1'b1;
                    take_val = item.data_byte;
                end
                else if (cls.is_digit)
                begin
                    if (phase_reg == PH_MAXC)
                        acc_val = (nv > MAXC_SAT) ? MAXC_SAT[ACC_W-1:0] : nv[ACC_W-1:0];
                    else if (phase_reg == PH_DATA)
                    begin
                        acc_val = nv[ACC_W-1:0];
                        if (nv > NV_W'(COLOUR_MAX))
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_OVERFLOW;
                        end
                    end
                    else
                    begin
                        acc_val = nv[ACC_W-1:0];
                        if (nv > DIM_MAX)
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_OVERFLOW;
                        end
                    end
                    acc_next = acc_val;
                    tok_next = 1'b1;
                    // end of file closes the pending token
                    if (item.end_of_file && !do_fail)
                    begin
                        do_fin  = 1'b1;
                        fin_val = acc_val;
                    end
                end
                else if (cls.is_space || cls.is_hash)
                begin
                    if (cls.is_hash)
                        comment_next = 1'b1;
                    if (tok_reg)
                    begin
                        do_fin  = 1'b1;
                        fin_val = acc_reg;
                    end
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CHAR;
                end
            end
            default:
            begin
            end
        endcase

        // token end
        if (do_fin)
        begin
            acc_next = '0;
            tok_next = 1'b0;
            unique case (phase_reg)
                PH_WIDTH:
                begin
                    width_next = fin_val[DIM_BITS-1:0];
                    phase_next = PH_HEIGHT;
                end
                PH_HEIGHT:
                begin
                    height_next = fin_val[DIM_BITS-1:0];
                    phase_next  = PH_MAXC;
                end
                PH_MAXC:
                begin
                    if (fin_val != ACC_W'(COLOUR_MAX))
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_MAXCOLOR;
                    end
                    else
                    begin
                        count_next           = '0;
                        comp_next            = 2'd0;
                        emit                 = 1'b1;
                        result.result_kind   = KIND_HEADER;
                        result.image_width   = width_ext[15:0];
                        result.image_height  = height_ext[15:0];
                        result.binary_format = fmt_reg;
                        result.last          = (width_reg == '0) || (height_reg == '0);
                        phase_next           = result.last ? PH_HALT : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    do_take  = 1'b1;
                    take_val = fin_val[7:0];
                end
                default:
                begin
                end
            endcase
        end

        // pixel component
        if (do_take)
        begin
            case (comp_reg)
                2'd0:
                begin
                    red_next  = take_val;
                    comp_next = 2'd1;
                end
                2'd1:
                begin
                    green_next = take_val;
                    comp_next  = 2'd2;
                end
                default:
                begin
                    comp_next            = 2'd0;
                    count_next           = count_inc;
                    emit                 = 1'b1;
                    result.result_kind   = KIND_PIXEL;
                    result.red           = red_reg;
                    result.green         = green_reg;
                    result.blue          = take_val;
                    result.binary_format = fmt_reg;
                    result.last          = (count_inc == total_reg);
                    if (result.last)
                        phase_next = PH_HALT;
                end
            endcase
        end

        if (do_fail)
        begin
            phase_next         = PH_HALT;
            tok_next           = 1'b0;
            acc_next           = '0;
            emit               = 1'b1;
            result             = '0;
            result.result_kind = KIND_ERROR;
            result.last        = 1'b1;
            result.error_code  = fail_code;
        end

        // restart after the final byte
        if (item.end_of_file)
        begin
            phase_next   = PH_MAGIC;
            comment_next = 1'b0;
            tok_next     = 1'b0;
            magic_next   = 2'd0;
            acc_next     = '0;
            width_next   = '0;
            height_next  = '0;
            fmt_next     = 1'b0;
            comp_next    = 2'd0;
            red_next     = '0;
            green_next   = '0;
            count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC;
            comment_reg <= 1'b0;
            tok_reg     <= 1'b0;
            magic_reg   <= 2'd0;
            acc_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            fmt_reg     <= 1'b0;
            comp_reg    <= 2'd0;
            red_reg     <= '0;
            green_reg   <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            tok_reg     <= tok_next;
            magic_reg   <= magic_next;
            acc_reg     <= acc_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            fmt_reg     <= fmt_next;
            comp_reg    <= comp_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            count_reg   <= count_next;
        end
    end

    // pixel total, settles well before the maxcolor token can end
    always_ff @(posedge clk)
    begin
        total_reg <= PC_W'(width_reg) * PC_W'(height_reg);
    end

endmodule

`default_nettype wire

@@ rtl/ppm_stream_parser_core.sv @@
// top level of the ppm stream parser: input register, parser, result register
`default_nettype none

// channel  direction  payload    transaction
// byte     in         pps_in_t   one byte of the file, end_of_file on the final byte
// result   out        pps_out_t  header, pixel or error record
//
// one byte per cycle unless the result side stalls; a byte waits in the input register
// and its result (if any) is written to the result register when the parser steps
// the per-byte update (magic, token accumulate, pixel assembly) is made on that step
// rst_n clears all control state asynchronously; parser restarts after end_of_file
// a stalled result holds the parser; byte_ready drops only when the input
// register is full and the result register cannot be emptied

module ppm_stream_parser_core #(
    parameter int DIM_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  pps_pkg::pps_in_t  byte_data,
    output logic              result_valid,
    input  logic              result_ready,
    output pps_pkg::pps_out_t result_data
);
    import pps_pkg::*;

    // input register
    logic     byte_vld_reg;
    pps_in_t  byte_data_reg;

    // result register
    logic     res_vld_reg;
    pps_out_t res_data_reg;

    logic       step;
    logic       emit;
    pps_out_t   parsed;
    pps_class_t cls;

    // parser advances when the result slot is free or being emptied
    assign step       = byte_vld_reg && (!res_vld_reg || result_ready);
    assign byte_ready = !byte_vld_reg || step;

    assign result_valid = res_vld_reg;
    assign result_data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_vld_reg <= 1'b0;
        else if (byte_ready)
            byte_vld_reg <= byte_valid;
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            byte_data_reg <= byte_data;
    end

    pps_byte_class u_class (
        .data_byte (byte_data_reg.data_byte),
        .cls       (cls)
    );

    pps_parser #(
        .DIM_BITS (DIM_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (byte_data_reg),
        .cls    (cls),
        .emit   (emit),
        .result (parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (step && emit)
            res_vld_reg <= 1'b1;
        else if (result_ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            res_data_reg <= parsed;
    end

    // checks
`include "assert_macros.svh"

    // full input register with a stalled result must back-pressure the byte side
    `ASSERT_IMPLIES(a_stall_blocks, clk, rst_n, byte_vld_reg && res_vld_reg && !result_ready, !byte_ready)
    // a byte that steps the parser leaves the input register or is replaced
    `ASSERT_NEXT(a_step_drains, clk, rst_n, step && !byte_valid, !byte_vld_reg)
    // error code is set exactly on error records
    `ASSERT_IMPLIES(a_err_code, clk, rst_n, res_vld_reg, (res_data_reg.result_kind == KIND_ERROR) == (res_data_reg.error_code != ERR_NONE))
    // pixel records carry no dimensions
    `ASSERT_IMPLIES(a_pix_dims, clk, rst_n, res_vld_reg && (res_data_reg.result_kind == KIND_PIXEL), (res_data_reg.image_width == 16'h0000) && (res_data_reg.image_height == 16'h0000))

endmodule

`default_nettype wire
